>>> rtl/core/ehsc_pkg.sv
// shared types, constants and hash helpers for the strided elf hash unit
// no dependencies
`default_nettype none

package ehsc_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [31:0] TOP_NIBBLE = 32'hF000_0000;

    typedef enum logic {
        OP_HASH = 1'b0,
        OP_LAST = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qpush;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [31:0] elf_step(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] t;
        logic [31:0] g;
        t = {h[27:0], 4'h0} + {24'h0, c};
        g = t & TOP_NIBBLE;
        t = t ^ (g >> 24);
        return t & ~TOP_NIBBLE;
    endfunction

    function automatic logic [15:0] fold16(input logic [31:0] s);
        return s[15:0] ^ s[31:16];
    endfunction

    function automatic logic [7:0] fold8(input logic [31:0] s);
        return s[7:0] ^ s[15:8] ^ s[23:16] ^ s[31:24];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ehsc_front.sv
// front end: takes input words, keeps the skip count and picks the bytes to hash
// depends on ehsc_pkg
`default_nettype none

module ehsc_front
    import ehsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [15:0] i_stride,
    output t_qpush           o_push
);

    logic [15:0] r_skip;
    logic [15:0] n_skip;

    always_comb begin
        n_skip               = r_skip;
        o_push.valid         = 1'b0;
        o_push.entry.op      = OP_HASH;
        o_push.entry.data    = i_byte;
        if (i_accept) begin
            priority if (i_last) begin
                o_push.valid    = 1'b1;
                o_push.entry.op = OP_LAST;
                n_skip          = '0;
            end else if (r_skip == '0) begin
                o_push.valid = 1'b1;
                n_skip       = (i_stride == '0) ? '0 : i_stride - 16'd1;
            end else begin
                n_skip = r_skip - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
        end else begin
            r_skip <= n_skip;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ehsc_queue.sv
// short queue between front and back end
// depends on ehsc_pkg
`default_nettype none

module ehsc_queue
    import ehsc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qpush i_push,
    input  wire logic   i_pop,
    output t_qentry     o_head,
    output t_qstat      o_stat
);

    t_qentry          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             w_do_pop;
    logic             w_do_push;

    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign w_do_push    = i_push.valid && !o_stat.full;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (w_do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ehsc_back.sv
// back end: running elf sum, folds and the output register
// depends on ehsc_pkg
`default_nettype none

module ehsc_back
    import ehsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_qentry     i_head,
    input  wire t_qstat      i_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [55:0]      o_data
);

    logic [31:0] r_sum;
    logic        r_valid;
    logic [55:0] r_data;
    logic        w_slot_free;

    assign w_slot_free = !r_valid || i_ready;
    assign o_pop       = !i_stat.empty && ((i_head.op == OP_HASH) || w_slot_free);
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop && (i_head.op == OP_LAST)) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_head.op)
                    OP_HASH: r_sum <= elf_step(r_sum, i_head.data);
                    OP_LAST: r_sum <= '0;
                    default: r_sum <= r_sum;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.op == OP_LAST)) begin
            r_data <= {fold8(r_sum), fold16(r_sum), r_sum};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/elf_hash_strided_checksum_unit.sv
// top level of the strided elf hash unit: stride register, front, queue, back
// depends on ehsc_pkg, ehsc_front, ehsc_queue, ehsc_back
`default_nettype none

// Takes one byte per cycle and hashes the
// first byte and then every stride-th one with the ELF/PJW step; the word
// with tlast high ends the pass, is not hashed, and yields one result word
// carrying the full sum and its 16- and 8-bit folds, after which the sum
// and skip count start again from zero. Sustained rate is one word per
// cycle: the front end classifies a word in the cycle it is taken, and the
// back end applies one hash step per cycle from a four-entry queue. A
// result is registered once its tlast word has left the queue behind any
// hash words queued ahead of it and the output register is free; while a
// result sits untaken the back end can still hash, and input stalls only
// once the queue fills behind a second pending tlast word.
// Write stride only while idle.

module elf_hash_strided_checksum_unit
    import ehsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // hash_full, fold_sixteen, fold_eight
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_stride;
    logic        w_accept;
    t_qpush      w_push;
    t_qentry     w_head;
    t_qstat      w_stat;
    logic        w_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0, r_stride} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 16'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_stride <= pwdata[15:0];
        end
    end

    assign s_axis_tready = !w_stat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ehsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_stride (r_stride),
        .o_push   (w_push)
    );

    ehsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    ehsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_top_nibble_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:28] == 4'h0))
        else $error("hash result has top nibble set");

    a_fold16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:32] == (m_axis_tdata[15:0] ^ m_axis_tdata[31:16])))
        else $error("16-bit fold does not match sum");

    a_fold8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[55:48] == (m_axis_tdata[7:0] ^ m_axis_tdata[15:8]
                                                  ^ m_axis_tdata[23:16] ^ m_axis_tdata[31:24])))
        else $error("8-bit fold does not match sum");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the strided elf hash unit: streams buffers in,
// predicts each result word and compares it field by field with the output
// depends on ehsc_pkg and elf_hash_strided_checksum_unit
module testbench;
    import ehsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] STRIDE_ADDR   = 3'd0;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         RANDOM_WORDS  = 650;

    typedef struct {
        logic [31:0] hash_full;
        logic [15:0] fold_sixteen;
        logic [7:0]  fold_eight;
    } t_sum_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // byte_in
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // hash_full, fold_sixteen, fold_eight
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_sum_word   pending_sums[$];
    logic [31:0] model_sum;
    logic [15:0] model_skip;
    logic [15:0] model_stride;
    int          errors;
    int          words_sent;
    int          idle_cycles;
    bit          src_burst;
    bit          sink_burst;

    elf_hash_strided_checksum_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pjw_absorb(input logic [31:0] sum, input logic [7:0] b);
        logic [31:0] t;
        t = {sum[27:0], 4'h0} + {24'h0, b};
        if (t[31:28] != 4'h0) begin
            t = t ^ {24'h0, t[31:28], 4'h0};
            t[31:28] = 4'h0;
        end
        return t;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input t_op kind);
        t_sum_word w;
        logic [15:0] step;
        if (kind == OP_LAST) begin
            w.hash_full    = model_sum;
            w.fold_sixteen = model_sum[15:0] ^ model_sum[31:16];
            w.fold_eight   = model_sum[7:0] ^ model_sum[15:8] ^ model_sum[23:16]
                           ^ model_sum[31:24];
            pending_sums.push_back(w);
            model_sum  = '0;
            model_skip = '0;
        end else if (model_skip == 16'd0) begin
            step       = (model_stride == 16'd0) ? 16'd1 : model_stride;
            model_sum  = pjw_absorb(model_sum, b);
            model_skip = step - 16'd1;
        end else begin
            model_skip = model_skip - 16'd1;
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input t_op kind);
        int gap;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= (kind == OP_LAST);
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(b, kind);
        words_sent++;
    endtask

    task automatic send_buffer(input int len);
        for (int k = 0; k < len; k++) send_word(8'($urandom), OP_HASH);
        send_word(8'($urandom), OP_LAST);
    endtask

    // let every expected word arrive and the hash queue run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stride(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STRIDE_ADDR;
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_stride = value;
    endtask

    task automatic test_single_item();
        send_word(8'hA5, OP_LAST);
        send_word(8'hFF, OP_LAST);
        settle();
    endtask

    task automatic test_top_nibble();
        repeat (9) send_word(8'hFF, OP_HASH);
        send_word(8'h00, OP_HASH);
        send_word(8'h00, OP_LAST);
        settle();
    endtask

    task automatic test_stride_extremes();
        write_stride(16'd0);
        send_word(8'h80, OP_HASH);
        send_word(8'h01, OP_HASH);
        send_word(8'h7F, OP_HASH);
        send_word(8'h55, OP_LAST);
        settle();
        write_stride(16'hFFFF);
        send_word(8'hC3, OP_HASH);
        send_word(8'hFF, OP_HASH);
        send_word(8'h3C, OP_HASH);
        send_word(8'h00, OP_LAST);
        settle();
    endtask

    task automatic test_stride_mid_pass();
        write_stride(16'd2);
        send_word(8'h12, OP_HASH);
        send_word(8'h34, OP_HASH);
        send_word(8'h56, OP_HASH);
        settle();
        write_stride(16'd1);
        send_word(8'h78, OP_HASH);
        send_word(8'h9A, OP_HASH);
        send_word(8'hBC, OP_LAST);
        settle();
    endtask

    task automatic pick_stride();
        case ($urandom_range(0, 7))
            0:       write_stride(16'd0);
            1:       write_stride(16'hFFFF);
            2, 7:    write_stride(16'd1);
            3:       write_stride(16'd2);
            4:       write_stride(16'd3);
            5:       write_stride(16'($urandom_range(4, 9)));
            default: write_stride(16'($urandom_range(1, 65535)));
        endcase
    endtask

    task automatic test_random_buffers();
        int goal;
        int len;
        int passes;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            pick_stride();
            passes = $urandom_range(1, 4);
            repeat (passes) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
                                                  : $urandom_range(0, 20);
                if (len > 2 && $urandom_range(0, 5) == 0) begin
                    // restride part way through a buffer
                    for (int k = 0; k < len / 2; k++) send_word(8'($urandom), OP_HASH);
                    settle();
                    pick_stride();
                    send_buffer(len - len / 2);
                end else begin
                    send_buffer(len);
                end
            end
            settle();
        end
    endtask

    always @(posedge i_clk) begin
        t_sum_word want;
        logic [31:0] got_full;
        logic [15:0] got_sixteen;
        logic [7:0]  got_eight;
        got_full    = m_axis_tdata[31:0];
        got_sixteen = m_axis_tdata[47:32];
        got_eight   = m_axis_tdata[55:48];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, actual %h", $time, m_axis_tdata);
            end else begin
                want = pending_sums.pop_front();
                if (got_full !== want.hash_full) begin
                    errors++;
                    $display("%0t: hash_full expected %h, actual %h",
                             $time, want.hash_full, got_full);
                end
                if (got_sixteen !== want.fold_sixteen) begin
                    errors++;
                    $display("%0t: fold_sixteen expected %h, actual %h",
                             $time, want.fold_sixteen, got_sixteen);
                end
                if (got_eight !== want.fold_eight) begin
                    errors++;
                    $display("%0t: fold_eight expected %h, actual %h",
                             $time, want.fold_eight, got_eight);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                     || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** elf_hash_strided_checksum_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        errors       = 0;
        words_sent   = 0;
        idle_cycles  = 0;
        src_burst    = 1'b0;
        sink_burst   = 1'b0;
        model_sum    = '0;
        model_skip   = '0;
        model_stride = 16'd1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_item();
        test_top_nibble();
        test_stride_extremes();
        test_stride_mid_pass();
        test_random_buffers();
        settle();

        if (errors == 0) begin
            $display("** elf_hash_strided_checksum_unit: PASSED **");
        end else begin
            $display("** elf_hash_strided_checksum_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ehsc_pkg.sv
rtl/core/ehsc_front.sv
rtl/core/ehsc_queue.sv
rtl/core/ehsc_back.sv
rtl/core/elf_hash_strided_checksum_unit.sv
sim/testbench.sv
